// ===== hw/rtl/mcs_pkg.sv =====
// Package for the MCTS child selection unit: sizes, the queued child record,
// queue handshake structs and the back-end sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcs_pkg;

    localparam int MAX_CHILDREN = 128;
    localparam int IDX_W        = $clog2(MAX_CHILDREN);
    localparam int CNT_W        = $clog2(MAX_CHILDREN + 1);

    localparam int Q_W          = 17;
    localparam int PRIOR_W      = 16;
    localparam int VISIT_W      = 24;
    localparam int DIV_W        = VISIT_W + 1;
    localparam int SCORE_W      = 18;
    localparam int OUT_IDX_W    = 7;

    localparam int DIV_STEPS    = PRIOR_W;
    localparam int STEP_W       = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [Q_W-1:0]     q_value;
        logic [PRIOR_W-1:0] prior;
        logic [DIV_W-1:0]   divisor;
        logic               unvisited;
        logic               active;
        logic [IDX_W-1:0]   index;
        logic               last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EVAL
    } t_back_state;

    function automatic logic [OUT_IDX_W-1:0] to_out_index(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mcts_child_select_unit.sv =====
// The back end takes one child at a time from the queue: it loads it, divides, then
// evaluates it before it takes the next; the divider gives one quotient bit per cycle.
// A two-entry queue lets the front accept while the back end is busy.
// Reset is synchronous, active low; it clears the queue, the sequencer,
// the child counter and both running selections. There is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mcts_child_select_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [mcs_pkg::Q_W-1:0]       i_q_value,
    input  wire logic [mcs_pkg::PRIOR_W-1:0]   i_prior,
    input  wire logic [mcs_pkg::VISIT_W-1:0]   i_visit_count,
    input  wire logic                          i_last_child,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [mcs_pkg::OUT_IDX_W-1:0]      o_best_score_index,
    output logic                               o_score_found,
    output logic [mcs_pkg::OUT_IDX_W-1:0]      o_best_new_index,
    output logic                               o_new_found
);
    import mcs_pkg::*;

    t_queue_push   push;
    t_queue_status status;
    t_item         head;
    logic          pop;

    mcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_q_value     (i_q_value),
        .i_prior       (i_prior),
        .i_visit_count (i_visit_count),
        .i_last_child  (i_last_child),
        .i_status      (status),
        .o_push        (push)
    );

    mcs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (status),
        .o_item   (head)
    );

    mcs_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_status           (status),
        .i_item             (head),
        .o_pop              (pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_best_score_index (o_best_score_index),
        .o_score_found      (o_score_found),
        .o_best_new_index   (o_best_new_index),
        .o_new_found        (o_new_found)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mcs_front.sv =====
// Front end: accepts child requests, numbers them within the node and
// classifies them before they enter the queue. Depends on mcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcs_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [mcs_pkg::Q_W-1:0]     i_q_value,
    input  wire logic [mcs_pkg::PRIOR_W-1:0] i_prior,
    input  wire logic [mcs_pkg::VISIT_W-1:0] i_visit_count,
    input  wire logic                        i_last_child,
    input  wire mcs_pkg::t_queue_status      i_status,
    output mcs_pkg::t_queue_push             o_push
);
    import mcs_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;
    logic             active;

    assign o_in_ready = !i_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign active     = (r_cnt < CNT_W'(MAX_CHILDREN));

    always_comb begin
        o_push.valid          = accept;
        o_push.item.q_value   = i_q_value;
        o_push.item.prior     = i_prior;
        o_push.item.divisor   = {1'b0, i_visit_count} + DIV_W'(1);
        o_push.item.unvisited = (i_visit_count == '0);
        o_push.item.active    = active;
        o_push.item.index     = r_cnt[IDX_W-1:0];
        o_push.item.last      = i_last_child;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            if (i_last_child) begin
                n_cnt = '0;
            end else if (active) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_CHILDREN))
        else $error("child counter beyond saturation limit");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mcs_queue.sv =====
// Short queue of classified child requests between front and back end.
// Depends on mcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcs_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mcs_pkg::t_queue_push   i_push,
    input  wire logic                   i_pop,
    output mcs_pkg::t_queue_status      o_status,
    output mcs_pkg::t_item              o_item
);
    import mcs_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_cnt;

    assign o_status.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_item         = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push.valid) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (i_push.valid && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (i_pop && !i_push.valid) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_cnt != QCNT_W'(QUEUE_DEPTH)))
        else $error("request pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mcs_back.sv =====
// Back end: bit-serial divider for prior / (1 + visits), the two running
// selections and the result register. Depends on mcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcs_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mcs_pkg::t_queue_status        i_status,
    input  wire mcs_pkg::t_item                i_item,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [mcs_pkg::OUT_IDX_W-1:0]      o_best_score_index,
    output logic                               o_score_found,
    output logic [mcs_pkg::OUT_IDX_W-1:0]      o_best_new_index,
    output logic                               o_new_found
);
    import mcs_pkg::*;

    t_back_state               r_state;
    t_back_state               n_state;
    t_item                     r_item;
    logic [DIV_W-1:0]          r_rem;
    logic [PRIOR_W-1:0]        r_quo;
    logic [STEP_W-1:0]         r_step;

    logic signed [SCORE_W-1:0] r_best_score;
    logic [IDX_W-1:0]          r_best_child;
    logic                      r_score_seen;
    logic [PRIOR_W-1:0]        r_best_prior;
    logic [IDX_W-1:0]          r_new_child;
    logic                      r_new_seen;
    logic                      r_out_valid;

    logic signed [SCORE_W-1:0] n_best_score;
    logic [IDX_W-1:0]          n_best_child;
    logic                      n_score_seen;
    logic [PRIOR_W-1:0]        n_best_prior;
    logic [IDX_W-1:0]          n_new_child;
    logic                      n_new_seen;

    logic                      load;
    logic                      step;
    logic                      commit;
    logic                      out_blocked;
    logic [DIV_W-1:0]          rem_shift;
    logic [DIV_W:0]            trial;
    logic                      fits;
    logic signed [SCORE_W-1:0] score;

    assign out_blocked = r_item.last && r_out_valid && !i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_status.empty) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = BK_EVAL;
                end
            end
            BK_EVAL: begin
                if (!out_blocked) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        load   = 1'b0;
        step   = 1'b0;
        commit = 1'b0;
        unique case (r_state)
            BK_IDLE: load   = !i_status.empty;
            BK_DIV:  step   = 1'b1;
            BK_EVAL: commit = !out_blocked;
            default: ;
        endcase
    end

    assign o_pop = load;

    assign rem_shift = {r_rem[DIV_W-2:0], r_quo[PRIOR_W-1]};
    assign trial     = {1'b0, rem_shift} - {1'b0, r_item.divisor};
    assign fits      = !trial[DIV_W];

    assign score = $signed({r_item.q_value[Q_W-1], r_item.q_value})
                 + $signed({2'b00, r_quo});

    always_comb begin
        n_best_score = r_best_score;
        n_best_child = r_best_child;
        n_score_seen = r_score_seen;
        n_best_prior = r_best_prior;
        n_new_child  = r_new_child;
        n_new_seen   = r_new_seen;
        if (r_item.active) begin
            if (score > r_best_score) begin
                n_best_score = score;
                n_best_child = r_item.index;
                n_score_seen = 1'b1;
            end
            if (r_item.unvisited && (r_item.prior > r_best_prior)) begin
                n_best_prior = r_item.prior;
                n_new_child  = r_item.index;
                n_new_seen   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_out_valid  <= 1'b0;
            r_best_score <= '0;
            r_best_child <= '0;
            r_score_seen <= 1'b0;
            r_best_prior <= '0;
            r_new_child  <= '0;
            r_new_seen   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit && r_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit) begin
                if (r_item.last) begin
                    r_best_score <= '0;
                    r_best_child <= '0;
                    r_score_seen <= 1'b0;
                    r_best_prior <= '0;
                    r_new_child  <= '0;
                    r_new_seen   <= 1'b0;
                end else begin
                    r_best_score <= n_best_score;
                    r_best_child <= n_best_child;
                    r_score_seen <= n_score_seen;
                    r_best_prior <= n_best_prior;
                    r_new_child  <= n_new_child;
                    r_new_seen   <= n_new_seen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
            r_rem  <= '0;
            r_quo  <= i_item.prior;
            r_step <= '0;
        end else if (step) begin
            r_rem  <= fits ? trial[DIV_W-1:0] : rem_shift;
            r_quo  <= {r_quo[PRIOR_W-2:0], fits};
            r_step <= r_step + STEP_W'(1);
        end
        if (commit && r_item.last) begin
            o_best_score_index <= n_score_seen ? to_out_index(n_best_child) : '0;
            o_score_found      <= n_score_seen;
            o_best_new_index   <= n_new_seen ? to_out_index(n_new_child) : '0;
            o_new_found        <= n_new_seen;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_rem < r_item.divisor))
        else $error("divider remainder not below divisor");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EVAL && out_blocked) |=> (r_state == BK_EVAL))
        else $error("node result committed over a pending result");

    a_seen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_score_seen || (r_best_child == '0 && r_best_score == '0))
        && (r_new_seen || (r_new_child == '0 && r_best_prior == '0)))
        else $error("selection state set without a found flag");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for mcts_child_select_unit: streams child requests
// and checks each node's two selections against an in-bench predictor.
// Depends on mcs_pkg and the mcts_child_select_unit RTL.
`timescale 1ns / 1ps

module tb_top;
    import mcs_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TARGET_ITEMS = 1450;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [OUT_IDX_W-1:0] score_index;
        logic                 score_found;
        logic [OUT_IDX_W-1:0] new_index;
        logic                 new_found;
    } t_selection;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [Q_W-1:0]       i_q_value;
    logic [PRIOR_W-1:0]   i_prior;
    logic [VISIT_W-1:0]   i_visit_count;
    logic                 i_last_child;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [OUT_IDX_W-1:0] o_best_score_index;
    logic                 o_score_found;
    logic [OUT_IDX_W-1:0] o_best_new_index;
    logic                 o_new_found;

    t_selection expected_selections[$];

    int                   node_child_index;
    logic signed [SCORE_W-1:0] top_score;
    int                   top_score_child;
    logic                 top_score_valid;
    logic [PRIOR_W-1:0]   top_new_prior;
    int                   top_new_child;
    logic                 top_new_valid;

    int   cycle_count;
    int   items_sent;
    int   nodes_checked;
    int   mismatch_count;
    bit   sender_gaps_on;
    bit   receiver_stalls_on;
    int   receiver_hold_cycles;
    int   stall_left;

    mcts_child_select_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_q_value          (i_q_value),
        .i_prior            (i_prior),
        .i_visit_count      (i_visit_count),
        .i_last_child       (i_last_child),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_best_score_index (o_best_score_index),
        .o_score_found      (o_score_found),
        .o_best_new_index   (o_best_new_index),
        .o_new_found        (o_new_found)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(30, 120);
    endfunction

    task automatic clear_node_selection();
        node_child_index = 0;
        top_score        = '0;
        top_score_child  = 0;
        top_score_valid  = 1'b0;
        top_new_prior    = '0;
        top_new_child    = 0;
        top_new_valid    = 1'b0;
    endtask

    task automatic predict_selection(input logic [Q_W-1:0] q, input logic [PRIOR_W-1:0] prior,
                                     input logic [VISIT_W-1:0] visits, input logic last);
        logic [DIV_W-1:0]          divisor;
        logic [PRIOR_W-1:0]        quotient;
        logic signed [SCORE_W-1:0] score;
        t_selection                sel;
        divisor  = DIV_W'(visits) + DIV_W'(1);
        quotient = PRIOR_W'(DIV_W'(prior) / divisor);
        score    = SCORE_W'(signed'(q)) + SCORE_W'(quotient);
        if (node_child_index < MAX_CHILDREN) begin
            if (score > top_score) begin
                top_score       = score;
                top_score_child = node_child_index;
                top_score_valid = 1'b1;
            end
            if (visits == '0 && prior > top_new_prior) begin
                top_new_prior = prior;
                top_new_child = node_child_index;
                top_new_valid = 1'b1;
            end
            node_child_index++;
        end
        if (last) begin
            sel.score_index = top_score_valid ? OUT_IDX_W'(top_score_child) : '0;
            sel.score_found = top_score_valid;
            sel.new_index   = top_new_valid ? OUT_IDX_W'(top_new_child) : '0;
            sel.new_found   = top_new_valid;
            expected_selections.push_back(sel);
            clear_node_selection();
        end
    endtask

    task automatic send_child(input logic [Q_W-1:0] q, input logic [PRIOR_W-1:0] prior,
                              input logic [VISIT_W-1:0] visits, input logic last);
        int gap;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_q_value     <= q;
        i_prior       <= prior;
        i_visit_count <= visits;
        i_last_child  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_selection(q, prior, visits, last);
        items_sent++;
        gap = sender_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_selections.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [Q_W-1:0] random_q(input bit cold);
        if (cold) begin
            return {1'b1, PRIOR_W'($urandom)};
        end
        case ($urandom_range(0, 7))
            0: return {1'b0, {(Q_W-1){1'b1}}};
            1: return {1'b1, {(Q_W-1){1'b0}}};
            2: return '0;
            3, 4: return {1'b1, PRIOR_W'($urandom)};
            default: return Q_W'($urandom);
        endcase
    endfunction

    function automatic logic [PRIOR_W-1:0] random_prior(input bit cold);
        if (cold) begin
            return PRIOR_W'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return PRIOR_W'($urandom_range(0, 15));
            default: return PRIOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [VISIT_W-1:0] random_visits();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4: return '1;
            5, 6: return VISIT_W'($urandom_range(1, 7));
            default: return VISIT_W'($urandom);
        endcase
    endfunction

    task automatic send_random_node(input int size);
        bit cold;
        cold = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < size; i++) begin
            send_child(random_q(cold), random_prior(cold), random_visits(), i == size - 1);
        end
    endtask

    function automatic int pick_node_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 8);
        end else if (r < 95) begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(100, MAX_CHILDREN);
    endfunction

    task automatic test_directed_cases();
        send_child({1'b0, {(Q_W-1){1'b1}}}, '1, '0, 1'b1);
        send_child({1'b1, {(Q_W-1){1'b0}}}, '0, '1, 1'b1);
        send_child('0, '0, '0, 1'b1);
        send_child('1, PRIOR_W'(2), '0, 1'b1);
        send_child(Q_W'(-100), '1, '1, 1'b0);
        send_child(Q_W'(200), '0, VISIT_W'(3), 1'b0);
        send_child(Q_W'(100), PRIOR_W'(200), VISIT_W'(1), 1'b0);
        send_child('0, PRIOR_W'(300), '0, 1'b1);
        send_child(Q_W'(-5), PRIOR_W'(700), '0, 1'b0);
        send_child(Q_W'(-5), PRIOR_W'(700), '0, 1'b0);
        send_child(Q_W'(-5), PRIOR_W'(900), VISIT_W'(2), 1'b1);
        send_child(Q_W'(1), '1, '1, 1'b1);
        send_child(Q_W'(-3), PRIOR_W'(4), VISIT_W'(1), 1'b0);
        send_child({1'b1, {(Q_W-1){1'b0}}}, '1, '0, 1'b1);
    endtask

    task automatic test_random_nodes(input int item_goal);
        while (items_sent < item_goal) begin
            send_random_node(pick_node_size());
        end
    endtask

    task automatic test_output_backpressure();
        receiver_hold_cycles = 400;
        for (int i = 0; i < 12; i++) begin
            send_random_node(1);
        end
    endtask

    task automatic test_sender_pause();
        for (int i = 0; i < 3; i++) begin
            send_random_node(pick_node_size());
            wait_for_results();
        end
    endtask

    task automatic test_oversized_nodes();
        int sizes[3];
        bit winner;
        sizes = '{MAX_CHILDREN, MAX_CHILDREN + 1, MAX_CHILDREN + 72};
        foreach (sizes[n]) begin
            for (int i = 0; i < sizes[n]; i++) begin
                winner = (i == MAX_CHILDREN - 1) || (i >= MAX_CHILDREN);
                if (winner) begin
                    send_child({1'b0, {(Q_W-1){1'b1}}}, '1, '0, i == sizes[n] - 1);
                end else begin
                    send_child(random_q(1'b0), random_prior(1'b0), random_visits(),
                               i == sizes[n] - 1);
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (receiver_hold_cycles == 0 && stall_left == 0 && receiver_stalls_on
                && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
        end
        if (receiver_hold_cycles > 0) begin
            receiver_hold_cycles--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_selection
        t_selection want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_selections.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("Unexpected result: score %0d/%0b new %0d/%0b",
                             o_best_score_index, o_score_found,
                             o_best_new_index, o_new_found);
                end
            end else begin
                want = expected_selections.pop_front();
                if (o_best_score_index !== want.score_index
                        || o_score_found !== want.score_found
                        || o_best_new_index !== want.new_index
                        || o_new_found !== want.new_found) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("Node %0d: expected score %0d/%0b new %0d/%0b, got %0d/%0b %0d/%0b",
                                 nodes_checked, want.score_index, want.score_found,
                                 want.new_index, want.new_found,
                                 o_best_score_index, o_score_found,
                                 o_best_new_index, o_new_found);
                    end
                end
            end
            nodes_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_q_value            = '0;
        i_prior              = '0;
        i_visit_count        = '0;
        i_last_child         = 1'b0;
        i_out_ready          = 1'b0;
        cycle_count          = 0;
        items_sent           = 0;
        nodes_checked        = 0;
        mismatch_count       = 0;
        sender_gaps_on       = 1'b0;
        receiver_stalls_on   = 1'b0;
        receiver_hold_cycles = 0;
        stall_left           = 0;
        clear_node_selection();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_nodes(400);
        test_output_backpressure();
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        test_sender_pause();
        test_oversized_nodes();
        test_random_nodes(TARGET_ITEMS);

        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
